>>> src/autokey_cipher_27_symbol_assert.svh
// Assertion macros for the autokey cipher block.
`ifndef AUTOKEY_CIPHER_27_SYMBOL_ASSERT_SVH
`define AUTOKEY_CIPHER_27_SYMBOL_ASSERT_SVH
`ifndef SYNTHESIS
`define AKC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define AKC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define AKC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define AKC_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> src/akc27_pkg.sv
// Shared types, codes and symbol tables for the autokey cipher.
package akc27_pkg;

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_KEY   = 2'd1;
  localparam logic [1:0] KIND_TEXT  = 2'd2;

  localparam logic [4:0] CODE_DOT   = 5'd26;
  localparam logic [5:0] ALPHA_SIZE = 6'd27;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_Z     = 8'h5A;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;

  typedef struct packed {
    logic       valid;
    logic [4:0] code;
  } sym_t;

  // Control half of a queued operation; addresses travel beside it.
  typedef struct packed {
    logic       is_text;
    logic       key_empty;
    logic       ovf;
    logic [4:0] code;
  } ctl_t;

  function automatic sym_t sym_decode(input logic [7:0] b);
    sym_t       s;
    logic [7:0] diff;
    diff = b - CHAR_A;
    s.valid = 1'b0;
    s.code  = diff[4:0];
    if (b >= CHAR_A && b <= CHAR_Z) begin
      s.valid = 1'b1;
    end else if (b == CHAR_DOT) begin
      s.valid = 1'b1;
      s.code  = CODE_DOT;
    end
    return s;
  endfunction

  function automatic logic [7:0] code_char(input logic [4:0] c);
    return (c == CODE_DOT) ? CHAR_DOT : CHAR_A + {3'b000, c};
  endfunction

endpackage

>>> src/akc27_ram.sv
// Simple dual-port RAM, one write and one registered read port.
module akc27_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/akc27_front.sv
// Front end: classifies beats and keeps the key queue pointers.
module akc27_front
  import akc27_pkg::*;
#(
  parameter int KEY_DEPTH = 64,
  localparam int AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1,
  localparam int CW = $clog2(KEY_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_stall,
  input  logic [1:0]    kind,
  input  logic [7:0]    symbol,
  input  logic          q_full,
  output logic          q_push,
  output ctl_t          q_ctl,
  output logic [AW-1:0] q_rd_addr,
  output logic [AW-1:0] q_wr_addr
);

  localparam int SW = CW + 1;

  logic [AW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  logic          ovf, ovf_next;
  logic          accept;
  sym_t          sym;
  logic [SW-1:0] tail_sum;
  logic [SW-1:0] tail_wrap;
  logic [AW-1:0] tail;
  logic [AW-1:0] head_inc;

  assign item_stall = q_full;
  assign accept     = item_valid && !q_full;
  assign sym        = sym_decode(symbol);

  always_comb begin
    tail_sum  = SW'(head) + SW'(count);
    tail_wrap = (tail_sum >= SW'(KEY_DEPTH)) ? tail_sum - SW'(KEY_DEPTH) : tail_sum;
    tail      = tail_wrap[AW-1:0];
    head_inc  = (head == AW'(KEY_DEPTH - 1)) ? '0 : head + AW'(1);
  end

  always_comb begin
    head_next = head;
    count_next = count;
    ovf_next = ovf;
    q_push = 1'b0;
    q_ctl.is_text = (kind == KIND_TEXT);
    q_ctl.key_empty = (count == '0);
    q_ctl.ovf = ovf;
    q_ctl.code = sym.code;
    q_rd_addr = head;
    q_wr_addr = tail;
    if (accept) begin
      unique case (kind)
        KIND_CLEAR: begin
          head_next  = '0;
          count_next = '0;
        end
        KIND_KEY: begin
          if (sym.valid) begin
            if (count == CW'(KEY_DEPTH)) begin
              ovf_next = 1'b1;
            end else begin
              q_push     = 1'b1;
              count_next = count + CW'(1);
            end
          end
        end
        KIND_TEXT: begin
          if (sym.valid) begin
            q_push = 1'b1;
            // pop then push back: count only moves when the queue was empty
            if (count == '0) begin
              count_next = CW'(1);
            end else begin
              head_next = head_inc;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
      ovf   <= 1'b0;
    end else begin
      head  <= head_next;
      count <= count_next;
      ovf   <= ovf_next;
    end
  end

endmodule

>>> src/akc27_fifo.sv
// Two-entry queue between front and back end.
module akc27_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  output logic         valid,
  input  logic         pop,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] slot [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   cnt;

  assign full     = (cnt == 2'd2);
  assign valid    = (cnt != 2'd0);
  assign pop_data = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> src/akc27_back.sv
// Back end: key RAM read, mod-27 combine, push-back write and result register.
module akc27_back
  import akc27_pkg::*;
#(
  parameter int KEY_DEPTH = 64,
  localparam int AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          encode_mode,
  input  logic          q_valid,
  input  ctl_t          q_ctl,
  input  logic [AW-1:0] q_rd_addr,
  input  logic [AW-1:0] q_wr_addr,
  output logic          q_pop,
  output logic          result_valid,
  input  logic          result_stall,
  output logic [7:0]    out_char,
  output logic [4:0]    out_code,
  output logic          key_overflow
);

  logic          s1_valid;
  ctl_t          s1_ctl;
  logic [AW-1:0] s1_wr_addr;
  logic          fwd;
  logic [4:0]    fwd_data;
  logic [4:0]    rdata;
  logic          out_free;
  logic          s1_adv;
  logic [4:0]    key;
  logic [5:0]    enc_sum;
  logic [5:0]    dec_sum;
  logic [4:0]    res;
  logic [4:0]    wdata;

  assign out_free = !result_valid || !result_stall;
  assign s1_adv   = s1_valid && (!s1_ctl.is_text || out_free);
  assign q_pop    = q_valid && (!s1_valid || s1_adv);

  akc27_ram #(
    .WIDTH(5),
    .DEPTH(KEY_DEPTH)
  ) u_key_ram (
    .clk  (clk),
    .we   (s1_adv),
    .waddr(s1_wr_addr),
    .wdata(wdata),
    .re   (q_pop),
    .raddr(q_rd_addr),
    .rdata(rdata)
  );

  always_comb begin
    key = s1_ctl.key_empty ? 5'd0 : (fwd ? fwd_data : rdata);
    enc_sum = {1'b0, s1_ctl.code} + {1'b0, key};
    if (enc_sum >= ALPHA_SIZE) begin
      enc_sum = enc_sum - ALPHA_SIZE;
    end
    if (s1_ctl.code >= key) begin
      dec_sum = {1'b0, s1_ctl.code} - {1'b0, key};
    end else begin
      dec_sum = {1'b0, s1_ctl.code} + ALPHA_SIZE - {1'b0, key};
    end
    res = encode_mode ? enc_sum[4:0] : dec_sum[4:0];
    // push-back value is always the plaintext symbol
    wdata = (s1_ctl.is_text && !encode_mode) ? res : s1_ctl.code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv && s1_ctl.is_text) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_ctl     <= q_ctl;
      s1_wr_addr <= q_wr_addr;
      // RAM read returns old data when the write lands on the same edge
      fwd        <= s1_adv && (q_rd_addr == s1_wr_addr);
      fwd_data   <= wdata;
    end
    if (s1_adv && s1_ctl.is_text) begin
      out_char     <= code_char(res);
      out_code     <= res;
      key_overflow <= s1_ctl.ovf;
    end
  end

endmodule

>>> src/autokey_cipher_27_symbol.sv
// Top level of the 27-symbol autokey Vigenere cipher.
//
//   channel  | direction | handshake                | payload
//   item     | in        | item_valid / item_stall  | kind, symbol
//   result   | out       | result_valid / result_stall | out_char, out_code, key_overflow
//   config   | in        | cfg_wen                  | cfg_wdata (encode_mode)
//
// One beat per cycle sustained while result_stall is low; a text beat reaches
// the result port through the queue slot, the key RAM read and the result
// register. The key RAM has one write and one read port; same-address
// write/read on one edge is covered by a bypass register. Reset clears
// pointers, queue and valid flags; the key RAM is not cleared.
// A result stall backs up through the back end into the two-entry queue, then
// onto item_stall.
module autokey_cipher_27_symbol
  import akc27_pkg::*;
#(
  parameter int KEY_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wen,
  input  logic       cfg_wdata,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [1:0] kind,
  input  logic [7:0] symbol,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] out_char,
  output logic [4:0] out_code,
  output logic       key_overflow
);

`include "autokey_cipher_27_symbol_assert.svh"

  localparam int AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int QW = $bits(ctl_t) + 2 * AW;

  logic          encode_mode;
  logic          q_push;
  logic          q_full;
  logic          q_valid;
  logic          q_pop;
  ctl_t          f_ctl;
  logic [AW-1:0] f_rd_addr;
  logic [AW-1:0] f_wr_addr;
  ctl_t          b_ctl;
  logic [AW-1:0] b_rd_addr;
  logic [AW-1:0] b_wr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      encode_mode <= 1'b0;
    end else if (cfg_wen) begin
      encode_mode <= cfg_wdata;
    end
  end

  akc27_front #(
    .KEY_DEPTH(KEY_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .kind      (kind),
    .symbol    (symbol),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_ctl     (f_ctl),
    .q_rd_addr (f_rd_addr),
    .q_wr_addr (f_wr_addr)
  );

  akc27_fifo #(
    .W(QW)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data({f_ctl, f_rd_addr, f_wr_addr}),
    .full     (q_full),
    .valid    (q_valid),
    .pop      (q_pop),
    .pop_data ({b_ctl, b_rd_addr, b_wr_addr})
  );

  akc27_back #(
    .KEY_DEPTH(KEY_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .encode_mode (encode_mode),
    .q_valid     (q_valid),
    .q_ctl       (b_ctl),
    .q_rd_addr   (b_rd_addr),
    .q_wr_addr   (b_wr_addr),
    .q_pop       (q_pop),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .out_char    (out_char),
    .out_code    (out_code),
    .key_overflow(key_overflow)
  );

  // a new result only follows an op popped from the queue earlier
  `AKC_ASSERT_IMP(a_result_from_pop, clk, rst, $rose(result_valid), $past(q_pop, 2))
  // queued ops are not lost while the back end holds
  `AKC_ASSERT_NXT(a_queue_holds, clk, rst, q_valid && !q_pop, q_valid)

endmodule

>>> sim/tb.sv
// Self-checking testbench for the 27-symbol autokey cipher block.
`timescale 1ns / 100ps

module tb;
  import akc27_pkg::*;

  localparam int KEY_DEPTH = 64;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam string ALPHABET = "ABCDEFGHIJKLMNOPQRSTUVWXYZ.";
  localparam int LONG_HOLD = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS = 130;
  localparam bit [7:0] MODE_PLAN = 8'b0110_1001;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] sym;
  } cipher_item_t;

  typedef struct packed {
    logic [7:0] ch;
    logic [4:0] code;
    logic       ovf;
  } cipher_out_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wen = 1'b0;
  logic       cfg_wdata = 1'b0;
  logic       item_valid = 1'b0;
  logic       item_stall;
  logic [1:0] kind = KIND_CLEAR;
  logic [7:0] symbol = 8'h00;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic [7:0] out_char;
  logic [4:0] out_code;
  logic       key_overflow;

  autokey_cipher_27_symbol #(.KEY_DEPTH(KEY_DEPTH)) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .kind         (kind),
    .symbol       (symbol),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_char     (out_char),
    .out_code     (out_code),
    .key_overflow (key_overflow)
  );

  always #5 clk = ~clk;

  // Predictor state: key FIFO, pointers, sticky flag, mode.
  logic [4:0]   key_mem [KEY_DEPTH];
  int unsigned  key_head = 0;
  int unsigned  key_count = 0;
  bit           ovf_flag = 1'b0;
  bit           enc_mode = 1'b0;

  cipher_item_t pending_items[$];
  cipher_out_t  expected_q[$];

  bit in_taken = 1'b0;
  bit out_taken = 1'b0;
  int errors = 0;
  int items_taken = 0;
  int results_seen = 0;
  int enc_results = 0;
  int ovf_results = 0;
  int clears_taken = 0;
  int useful_count = 0;
  int hold_reqs = 0;
  int hold_served = 0;
  int hold_left = 0;
  int stall_left = 0;
  int wait_cnt = 0;
  int idle_cycles = 0;
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;

  function automatic int sym_index(input logic [7:0] b);
    if (b >= CHAR_A && b <= CHAR_Z) return int'(b) - int'(CHAR_A);
    if (b == CHAR_DOT) return 26;
    return -1;
  endfunction

  function automatic void key_push(input int c);
    key_mem[(key_head + key_count) % KEY_DEPTH] = 5'(c);
    key_count++;
  endfunction

  // Advance the cipher state by one beat; queue a result for text beats.
  function automatic void cipher_step(input logic [1:0] k, input logic [7:0] s);
    int c;
    int kc;
    int r;
    cipher_out_t res;
    c = sym_index(s);
    case (k)
      KIND_CLEAR: begin
        key_head = 0;
        key_count = 0;
        clears_taken++;
      end
      KIND_KEY: begin
        if (c >= 0) begin
          if (key_count >= KEY_DEPTH) ovf_flag = 1'b1;
          else key_push(c);
        end
      end
      KIND_TEXT: begin
        if (c >= 0) begin
          kc = 0;
          if (key_count != 0) begin
            kc = key_mem[key_head];
            key_head = (key_head + 1) % KEY_DEPTH;
            key_count--;
          end
          if (enc_mode) begin
            r = (c + kc) % 27;
            key_push(c);
            enc_results++;
          end else begin
            r = (c + 27 - kc) % 27;
            key_push(r);
          end
          res.ch = ALPHABET[r];
          res.code = 5'(r);
          res.ovf = ovf_flag;
          if (ovf_flag) ovf_results++;
          expected_q.push_back(res);
        end
      end
      default: ;
    endcase
  endfunction

  // Input side: take beats and predict.
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= item_valid && !item_stall;
      if (item_valid && !item_stall) begin
        cipher_step(kind, symbol);
        items_taken++;
      end
    end
  end

  // Driver: presents pending items, random gap after each beat.
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      wait_cnt <= 0;
    end else if (!item_valid || in_taken) begin
      if (wait_cnt != 0) begin
        item_valid <= 1'b0;
        wait_cnt <= wait_cnt - 1;
      end else if (pending_items.size() != 0) begin
        kind <= pending_items[0].kind;
        symbol <= pending_items[0].sym;
        void'(pending_items.pop_front());
        item_valid <= 1'b1;
        if ($urandom_range(0, 49) == 0) tx_burst <= !tx_burst;
        wait_cnt <= tx_burst ? 0 : $urandom_range(0, 10);
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall per result, plus requested long hold-offs.
  always @(negedge clk) begin : rx_drive
    int d;
    if (rst) begin
      result_stall <= 1'b0;
      stall_left <= 0;
    end else if (hold_served != hold_reqs) begin
      hold_served <= hold_reqs;
      hold_left <= LONG_HOLD;
      result_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      result_stall <= 1'b1;
    end else if (out_taken) begin
      if ($urandom_range(0, 49) == 0) rx_burst <= !rx_burst;
      d = rx_burst ? 0 : $urandom_range(0, 10);
      stall_left <= d;
      result_stall <= (d != 0);
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
      result_stall <= 1'b1;
    end else begin
      stall_left <= 0;
      result_stall <= 1'b0;
    end
  end

  // Result checker.
  always @(posedge clk) begin : result_check
    cipher_out_t want;
    if (rst) begin
      out_taken <= 1'b0;
    end else begin
      out_taken <= result_valid && !result_stall;
      if (result_valid && !result_stall) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          $error("result beat with nothing expected: out_char %h out_code %0d",
                 out_char, out_code);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (out_char !== want.ch) begin
            $error("out_char: expected %h, got %h", want.ch, out_char);
            errors++;
          end
          if (out_code !== want.code) begin
            $error("out_code: expected %0d, got %0d", want.code, out_code);
            errors++;
          end
          if (key_overflow !== want.ovf) begin
            $error("key_overflow: expected %b, got %b", want.ovf, key_overflow);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $error("watchdog: no beat for %0d cycles, %0d results outstanding",
             idle_cycles, expected_q.size());
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic add_item(input logic [1:0] k, input logic [7:0] s);
    cipher_item_t it;
    it.kind = k;
    it.sym = s;
    pending_items.push_back(it);
    if (k == KIND_CLEAR || (k != KIND_UNUSED && sym_index(s) >= 0)) useful_count++;
  endtask

  function automatic logic [7:0] pick_letter();
    int c;
    c = $urandom_range(0, 26);
    return ALPHABET[c];
  endfunction

  // One message: optional clear, key, text with the odd bad byte, trailing noise.
  task automatic add_message(input bit allow_overflow);
    int nkey;
    int ntext;
    int j;
    if ($urandom_range(0, 3) != 0) add_item(KIND_CLEAR, 8'($urandom_range(0, 255)));
    if (allow_overflow && $urandom_range(0, 9) == 0) nkey = $urandom_range(60, 70);
    else nkey = $urandom_range(1, 12);
    for (j = 0; j < nkey; j++) add_item(KIND_KEY, pick_letter());
    ntext = $urandom_range(1, 20);
    for (j = 0; j < ntext; j++) begin
      if ($urandom_range(0, 9) == 0) add_item(KIND_TEXT, 8'($urandom_range(0, 255)));
      else add_item(KIND_TEXT, pick_letter());
    end
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 4))
        add_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic write_mode(input bit m);
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_wen <= 1'b0;
    enc_mode = m;
  endtask

  // Block idle: all items taken, all results back, pipeline flushed.
  task automatic wait_drained();
    @(posedge clk);
    while (pending_items.size() != 0 || item_valid || expected_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stim
    int ph;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Encode: empty-queue text, alphabet ends, bad bytes, unused kind.
    write_mode(1'b1);
    add_item(KIND_CLEAR, 8'h00);
    add_item(KIND_TEXT, "M");
    add_item(KIND_CLEAR, 8'hFF);
    add_item(KIND_KEY, "A");
    add_item(KIND_KEY, ".");
    add_item(KIND_KEY, "Z");
    add_item(KIND_KEY, 8'h40);
    add_item(KIND_KEY, 8'h5B);
    add_item(KIND_TEXT, "A");
    add_item(KIND_TEXT, ".");
    add_item(KIND_TEXT, "Z");
    add_item(KIND_TEXT, 8'h2D);
    add_item(KIND_TEXT, 8'h2F);
    add_item(KIND_TEXT, 8'h61);
    add_item(KIND_UNUSED, "A");
    add_item(KIND_TEXT, 8'hFF);
    add_item(KIND_TEXT, ".");
    wait_drained();

    // Decode: wrap on subtract, empty-queue text after clear.
    write_mode(1'b0);
    add_item(KIND_CLEAR, 8'h00);
    add_item(KIND_KEY, ".");
    add_item(KIND_TEXT, "A");
    add_item(KIND_TEXT, ".");
    add_item(KIND_CLEAR, 8'h55);
    add_item(KIND_TEXT, "A");
    add_item(KIND_UNUSED, 8'h00);
    wait_drained();

    // Random messages; overflow only late so the flag stays low for a while.
    for (ph = 0; ph < 8; ph++) begin
      write_mode(MODE_PLAN[ph]);
      useful_count = 0;
      while (useful_count < PHASE_ITEMS) add_message(ph >= 4);
      if (ph == 2 || ph == 5) hold_reqs++;
      wait_drained();
    end

    $display("%0d beats taken (%0d clears), %0d results checked over 10 phases",
             items_taken, clears_taken, results_seen);
    $display("%0d results encoded, %0d with key overflow set, %0d mismatches",
             enc_results, ovf_results, errors);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/akc27_pkg.sv
src/akc27_ram.sv
src/akc27_front.sv
src/akc27_fifo.sv
src/akc27_back.sv
src/autokey_cipher_27_symbol.sv
sim/tb.sv
